// ----- rtl/core/x86_branch_decode_and_condition_top_assert.svh -----
// assertion macros for the branch decoder
`ifndef X86_BRANCH_DECODE_AND_CONDITION_TOP_ASSERT_SVH
`define X86_BRANCH_DECODE_AND_CONDITION_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define XBDC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");
`define XBDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle");
`else
`define XBDC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define XBDC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/xbdc_pkg.sv -----
package xbdc_pkg;

   localparam int REQ_DATA_W = 248;
   localparam int RSP_DATA_W = 128;
   localparam int RSP_USER_W = 4;

   typedef enum logic [2:0] {
      KIND_CALL     = 3'd0,
      KIND_JUMP     = 3'd1,
      KIND_COND     = 3'd2,
      KIND_DYN_CALL = 3'd3,
      KIND_DYN_JUMP = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      COND_NOT_TAKEN = 2'd0,
      COND_TAKEN     = 2'd1,
      COND_NONE      = 2'd2
   } cond_type;

   localparam logic [4:0] REG_RIP        = 5'd16;
   localparam logic [4:0] REG_NONE_BASE  = 5'd17;
   localparam logic [4:0] REG_NONE_INDEX = 5'd16;

   localparam logic [7:0] OP_ESCAPE   = 8'h0f;
   localparam logic [7:0] OP_CALL_REL = 8'he8;
   localparam logic [7:0] OP_JMP_REL  = 8'he9;
   localparam logic [7:0] OP_JMP_SHRT = 8'heb;
   localparam logic [7:0] OP_JRCXZ    = 8'he3;
   localparam logic [7:0] OP_GRP5     = 8'hff;

   localparam logic [2:0] GRP5_CALL     = 3'd2;
   localparam logic [2:0] GRP5_CALL_FAR = 3'd3;
   localparam logic [2:0] GRP5_JMP      = 3'd4;

   localparam logic [1:0] MOD_REG = 2'd3;
   localparam logic [1:0] MOD_IND = 2'd0;
   localparam logic [2:0] RM_SIB  = 3'd4;
   localparam logic [2:0] RM_DISP = 3'd5;
   localparam logic [3:0] REX_HI  = 4'h4;
   localparam logic [3:0] IDX_NONE = 4'd4;

   localparam int CF_POS = 0;
   localparam int PF_POS = 2;
   localparam int ZF_POS = 6;
   localparam int SF_POS = 7;
   localparam int OF_POS = 11;

   typedef struct packed {
      logic [63:0] count_register;
      logic [11:0] flag_bits;
      logic [31:0] displacement_value;
      logic [31:0] immediate_value;
      logic [7:0]  sib_byte;
      logic [7:0]  modrm_byte;
      logic [7:0]  rex_byte;
      logic [7:0]  opcode_second;
      logic [7:0]  opcode_first;
      logic [3:0]  insn_length;
      logic [63:0] insn_address;
   } insn_type;

   function automatic cond_type cond_eval(input logic [7:0] op, input logic [11:0] flags,
                                          input logic rcx_zero);
      logic cf, pf, zf, sf, of, t;
      cond_type res;
      cf = flags[CF_POS];
      pf = flags[PF_POS];
      zf = flags[ZF_POS];
      sf = flags[SF_POS];
      of = flags[OF_POS];
      t = 1'b0;
      res = COND_NONE;
      unique case (op)
         8'h70: t = of;
         8'h71: t = !of;
         8'h72: t = cf;
         8'h73: t = !cf;
         8'h74: t = zf;
         8'h75: t = !zf;
         8'h76: t = cf | zf;
         8'h77: t = !cf & !zf;
         8'h78: t = sf;
         8'h79: t = !sf;
         8'h7a: t = pf;
         8'h7b: t = !pf;
         8'h7c: t = sf ^ of;
         8'h7d: t = !(sf ^ of);
         8'h7e: t = zf | (sf ^ of);
         8'h7f: t = !zf & !(sf ^ of);
         OP_JRCXZ: t = rcx_zero;
         OP_JMP_REL, OP_JMP_SHRT, OP_GRP5: t = 1'b1;
         default: res = COND_NONE;
      endcase
      if (op[7:4] == 4'h7 || op == OP_JRCXZ || op == OP_JMP_REL || op == OP_JMP_SHRT ||
          op == OP_GRP5) begin
         res = t ? COND_TAKEN : COND_NOT_TAKEN;
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/x86_branch_decode_and_condition_top.sv -----
// x86-64 branch decoder and condition evaluator
//
// req channel: one length-decoded instruction per transfer, with the flags
// and rcx current at that instruction. rsp channel: one result per request,
// in order: branch class in tuser, short-form opcode, direct target,
// condition outcome and the operands of an indirect target in tdata.
//
// an input register feeds a single pass of decode logic (a 64-bit target
// adder and a few narrow selects) that loads the result register; a request
// passes through the input register and then the result register, and one
// instruction is taken every cycle while rsp_tready stays high.
// when the receiver stalls, the result register holds its item and the
// input register still fills, after which req_tready drops until the
// result is taken; nothing is dropped or repeated.
// reset empties both registers; no state carries from one instruction to
// the next.
module x86_branch_decode_and_condition_top
   import xbdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // insn_address, insn_length, opcode_first, opcode_second, rex_byte, modrm_byte,
   // sib_byte, immediate_value, displacement_value, flag_bits, count_register
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // canonical_opcode, direct_target, condition_outcome, target_in_memory,
   // base_register, index_register, index_scale, target_displacement, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // is_branch, branch_kind
   output logic [RSP_USER_W-1:0] rsp_tuser
);

`include "x86_branch_decode_and_condition_top_assert.svh"

   logic       s1_valid_ff, s1_valid_in;
   insn_type   s1_insn_ff;
   logic       out_valid_ff, out_valid_in;
   logic       out_ready;
   logic       req_take;

   logic        r_is_branch_ff, r_is_branch_in;
   kind_type    r_kind_ff, r_kind_in;
   logic [7:0]  r_canon_ff, r_canon_in;
   logic [63:0] r_target_ff, r_target_in;
   cond_type    r_cond_ff, r_cond_in;
   logic        r_in_mem_ff, r_in_mem_in;
   logic [4:0]  r_base_ff, r_base_in;
   logic [4:0]  r_index_ff, r_index_in;
   logic [3:0]  r_scale_ff, r_scale_in;
   logic [31:0] r_disp_ff, r_disp_in;

   // handshake: output register frees when empty or being read
   assign out_ready    = !out_valid_ff || rsp_tready;
   assign req_tready   = !s1_valid_ff || out_ready;
   assign req_take     = req_tvalid && req_tready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !out_ready);
   assign out_valid_in = out_ready ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_insn_ff <= insn_type'(req_tdata);
      end
   end

   // decode
   logic       rex_b, rex_x;
   logic [1:0] modf;
   logic [2:0] regf, rmf;
   logic       dynamic;
   logic [3:0] sidx;

   always_comb begin
      rex_b = 1'b0;
      rex_x = 1'b0;
      if (s1_insn_ff.rex_byte[7:4] == REX_HI) begin
         rex_b = s1_insn_ff.rex_byte[0];
         rex_x = s1_insn_ff.rex_byte[1];
      end
      modf = s1_insn_ff.modrm_byte[7:6];
      regf = s1_insn_ff.modrm_byte[5:3];
      rmf  = s1_insn_ff.modrm_byte[2:0];
      sidx = {rex_x, s1_insn_ff.sib_byte[5:3]};

      r_is_branch_in = 1'b1;
      r_kind_in      = KIND_CALL;
      r_canon_in     = s1_insn_ff.opcode_first;
      r_target_in    = s1_insn_ff.insn_address + {60'd0, s1_insn_ff.insn_length}
                       + {{32{s1_insn_ff.immediate_value[31]}}, s1_insn_ff.immediate_value};
      dynamic        = 1'b0;

      priority if (s1_insn_ff.opcode_first == OP_CALL_REL) begin
         r_kind_in = KIND_CALL;
      end else if (s1_insn_ff.opcode_first == OP_JMP_REL ||
                   s1_insn_ff.opcode_first == OP_JMP_SHRT) begin
         r_kind_in = KIND_JUMP;
      end else if (s1_insn_ff.opcode_first == OP_JRCXZ ||
                   s1_insn_ff.opcode_first[7:4] == 4'h7) begin
         r_kind_in = KIND_COND;
      end else if (s1_insn_ff.opcode_first == OP_ESCAPE &&
                   s1_insn_ff.opcode_second[7:4] == 4'h8) begin
         // near jcc maps onto its short form
         r_kind_in  = KIND_COND;
         r_canon_in = {4'h7, s1_insn_ff.opcode_second[3:0]};
      end else if (s1_insn_ff.opcode_first == OP_GRP5 &&
                   (regf == GRP5_CALL || regf == GRP5_CALL_FAR)) begin
         r_kind_in = KIND_DYN_CALL;
         dynamic   = 1'b1;
      end else if (s1_insn_ff.opcode_first == OP_GRP5 && regf == GRP5_JMP) begin
         r_kind_in = KIND_DYN_JUMP;
         dynamic   = 1'b1;
      end else begin
         r_is_branch_in = 1'b0;
         r_canon_in     = 8'd0;
         r_target_in    = 64'd0;
      end

      r_in_mem_in = 1'b0;
      r_base_in   = REG_NONE_BASE;
      r_index_in  = REG_NONE_INDEX;
      r_scale_in  = 4'd0;
      r_disp_in   = 32'd0;
      if (dynamic) begin
         r_target_in = 64'd0;
         r_base_in   = {1'b0, rex_b, rmf};
         r_disp_in   = s1_insn_ff.displacement_value;
         if (modf != MOD_REG) begin
            r_in_mem_in = 1'b1;
            if (modf == MOD_IND && rmf == RM_DISP) begin
               r_base_in = REG_RIP;
            end else if (rmf == RM_SIB) begin
               // sib addressing: base, optional index and scale
               r_base_in = {1'b0, rex_b, s1_insn_ff.sib_byte[2:0]};
               if (s1_insn_ff.sib_byte[2:0] == RM_DISP && modf == MOD_IND) begin
                  r_base_in = REG_NONE_BASE;
               end
               r_index_in = (sidx == IDX_NONE) ? REG_NONE_INDEX : {1'b0, sidx};
               r_scale_in = 4'd1 << s1_insn_ff.sib_byte[7:6];
            end
         end
      end

      r_cond_in = r_is_branch_in
                  ? cond_eval(r_canon_in, s1_insn_ff.flag_bits,
                              s1_insn_ff.count_register == 64'd0)
                  : COND_NONE;
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         r_is_branch_ff <= r_is_branch_in;
         r_kind_ff      <= r_kind_in;
         r_canon_ff     <= r_canon_in;
         r_target_ff    <= r_target_in;
         r_cond_ff      <= r_cond_in;
         r_in_mem_ff    <= r_in_mem_in;
         r_base_ff      <= r_base_in;
         r_index_ff     <= r_index_in;
         r_scale_ff     <= r_scale_in;
         r_disp_ff      <= r_disp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = {r_kind_ff, r_is_branch_ff};
   assign rsp_tdata  = {7'd0, r_disp_ff, r_scale_ff, r_index_ff, r_base_ff, r_in_mem_ff,
                        r_cond_ff, r_target_ff, r_canon_ff};

   `XBDC_ASSERT_NEXT(a_pass_to_output, clock, reset, s1_valid_ff && out_ready, out_valid_ff)
   `XBDC_ASSERT_IMPLIES(a_scale_onehot, clock, reset, out_valid_ff, $onehot0(r_scale_ff))
   `XBDC_ASSERT_IMPLIES(a_non_branch_defaults, clock, reset, out_valid_ff && !r_is_branch_ff,
      r_cond_ff == COND_NONE && r_base_ff == REG_NONE_BASE && r_target_ff == 64'd0)
   `XBDC_ASSERT_IMPLIES(a_dynamic_no_target, clock, reset,
      out_valid_ff && (r_kind_ff == KIND_DYN_CALL || r_kind_ff == KIND_DYN_JUMP),
      r_target_ff == 64'd0 && r_cond_ff == COND_TAKEN)
   `XBDC_ASSERT_IMPLIES(a_register_operand, clock, reset,
      out_valid_ff && r_is_branch_ff && !r_in_mem_ff,
      r_index_ff == REG_NONE_INDEX && r_scale_ff == 4'd0)

endmodule

// ----- verif/xbdc_branch_checker.sv -----
package xbdc_tb_pkg;

   import xbdc_pkg::*;

   // high nibbles of the short and near conditional jump opcodes
   localparam logic [3:0] JCC_SHORT_HI = 4'h7;
   localparam logic [3:0] JCC_NEAR_HI  = 4'h8;

   localparam logic [1:0] MOD_DISP8  = 2'd1;
   localparam logic [1:0] MOD_DISP32 = 2'd2;

   localparam logic [2:0] GRP5_INC  = 3'd0;
   localparam logic [2:0] GRP5_PUSH = 3'd6;
   localparam logic [2:0] GRP5_RSVD = 3'd7;

   localparam logic [7:0] OP_NOP = 8'h90;

   // flag tests of the jcc family, selected by opcode bits 3:1, bit 0 inverts
   typedef enum logic [2:0] {
      CC_OVERFLOW = 3'd0,
      CC_CARRY    = 3'd1,
      CC_ZERO     = 3'd2,
      CC_BELOW_EQ = 3'd3,
      CC_SIGN     = 3'd4,
      CC_PARITY   = 3'd5,
      CC_LESS     = 3'd6,
      CC_LESS_EQ  = 3'd7
   } cc_group_type;

   typedef struct packed {
      logic        is_branch;
      kind_type    kind;
      logic [7:0]  opcode;
      logic [63:0] target;
      cond_type    outcome;
      logic        in_memory;
      logic [4:0]  base_reg;
      logic [4:0]  index_reg;
      logic [3:0]  scale;
      logic [31:0] disp;
   } decoded_branch_type;

endpackage

module xbdc_branch_checker
   import xbdc_pkg::*;
   import xbdc_tb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [RSP_USER_W-1:0] rsp_tuser,
   output int                    mismatch_count,
   output int                    results_owed
);

   decoded_branch_type decoded_q[$];
   int                 result_no;

   function automatic cond_type resolve_condition(input logic [7:0] op,
                                                  input logic [11:0] flags,
                                                  input logic [63:0] rcx);
      logic cf, pf, zf, sf, ov, hit;
      cf = flags[CF_POS];
      pf = flags[PF_POS];
      zf = flags[ZF_POS];
      sf = flags[SF_POS];
      ov = flags[OF_POS];
      if (op[7:4] == JCC_SHORT_HI) begin
         case (cc_group_type'(op[3:1]))
            CC_OVERFLOW: hit = ov;
            CC_CARRY:    hit = cf;
            CC_ZERO:     hit = zf;
            CC_BELOW_EQ: hit = cf | zf;
            CC_SIGN:     hit = sf;
            CC_PARITY:   hit = pf;
            CC_LESS:     hit = sf ^ ov;
            default:     hit = zf | (sf ^ ov);
         endcase
         return (hit ^ op[0]) ? COND_TAKEN : COND_NOT_TAKEN;
      end
      if (op == OP_JRCXZ)
         return (rcx == '0) ? COND_TAKEN : COND_NOT_TAKEN;
      if (op == OP_JMP_REL || op == OP_JMP_SHRT || op == OP_GRP5)
         return COND_TAKEN;
      return COND_NONE;
   endfunction

   function automatic decoded_branch_type decode_branch(input insn_type insn);
      decoded_branch_type d;
      logic          rex_ok, rex_b, rex_x, indirect;
      logic [1:0]    md;
      logic [2:0]    rg, rm;
      logic [3:0]    sib_idx;
      d.is_branch = 1'b1;
      d.kind      = KIND_CALL;
      d.opcode    = insn.opcode_first;
      d.target    = insn.insn_address + 64'(insn.insn_length)
                    + {{32{insn.immediate_value[31]}}, insn.immediate_value};
      d.outcome   = COND_NONE;
      d.in_memory = 1'b0;
      d.base_reg  = REG_NONE_BASE;
      d.index_reg = REG_NONE_INDEX;
      d.scale     = '0;
      d.disp      = '0;
      indirect    = 1'b0;
      // a rex byte outside 4x counts as no prefix
      rex_ok = insn.rex_byte[7:4] == REX_HI;
      rex_b  = rex_ok & insn.rex_byte[0];
      rex_x  = rex_ok & insn.rex_byte[1];
      md     = insn.modrm_byte[7:6];
      rg     = insn.modrm_byte[5:3];
      rm     = insn.modrm_byte[2:0];

      if (insn.opcode_first == OP_CALL_REL) begin
         d.kind = KIND_CALL;
      end else if (insn.opcode_first == OP_JMP_REL || insn.opcode_first == OP_JMP_SHRT) begin
         d.kind = KIND_JUMP;
      end else if (insn.opcode_first == OP_JRCXZ || insn.opcode_first[7:4] == JCC_SHORT_HI) begin
         d.kind = KIND_COND;
      end else if (insn.opcode_first == OP_ESCAPE && insn.opcode_second[7:4] == JCC_NEAR_HI) begin
         d.kind   = KIND_COND;
         d.opcode = {JCC_SHORT_HI, insn.opcode_second[3:0]};
      end else if (insn.opcode_first == OP_GRP5 && (rg == GRP5_CALL || rg == GRP5_CALL_FAR)) begin
         d.kind   = KIND_DYN_CALL;
         indirect = 1'b1;
      end else if (insn.opcode_first == OP_GRP5 && rg == GRP5_JMP) begin
         d.kind   = KIND_DYN_JUMP;
         indirect = 1'b1;
      end else begin
         d.is_branch = 1'b0;
         d.opcode    = '0;
         d.target    = '0;
      end

      if (indirect) begin
         d.target   = '0;
         d.base_reg = {1'b0, rex_b, rm};
         d.disp     = insn.displacement_value;
         if (md != MOD_REG) begin
            d.in_memory = 1'b1;
            if (md == MOD_IND && rm == RM_DISP) begin
               d.base_reg = REG_RIP;
            end else if (rm == RM_SIB) begin
               sib_idx = {rex_x, insn.sib_byte[5:3]};
               // no base register when mod 0 meets sib base 5, rex.b notwithstanding
               if (md == MOD_IND && insn.sib_byte[2:0] == RM_DISP)
                  d.base_reg = REG_NONE_BASE;
               else
                  d.base_reg = {1'b0, rex_b, insn.sib_byte[2:0]};
               d.index_reg = (sib_idx == IDX_NONE) ? REG_NONE_INDEX : {1'b0, sib_idx};
               d.scale     = 4'd1 << insn.sib_byte[7:6];
            end
         end
      end

      d.outcome = d.is_branch ? resolve_condition(d.opcode, insn.flag_bits,
                                                  insn.count_register)
                              : COND_NONE;
      return d;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] branch result %0d: %s", $realtime, result_no, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
   endtask

   always @(posedge clock) begin
      decoded_branch_type want;
      if (reset) begin
         decoded_q.delete();
         mismatch_count = 0;
         result_no      = 0;
         results_owed  <= 0;
      end else begin
         if (req_tvalid && req_tready)
            decoded_q.push_back(decode_branch(insn_type'(req_tdata)));
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               report_mismatch("transfer with no instruction outstanding");
            end else begin
               want = decoded_q.pop_front();
               compare_field("is_branch", 64'(rsp_tuser[0]), 64'(want.is_branch));
               compare_field("branch_kind", 64'(rsp_tuser[3:1]), 64'(want.kind));
               compare_field("canonical_opcode", 64'(rsp_tdata[7:0]), 64'(want.opcode));
               compare_field("direct_target", rsp_tdata[71:8], want.target);
               compare_field("condition_outcome", 64'(rsp_tdata[73:72]), 64'(want.outcome));
               compare_field("target_in_memory", 64'(rsp_tdata[74]), 64'(want.in_memory));
               compare_field("base_register", 64'(rsp_tdata[79:75]), 64'(want.base_reg));
               compare_field("index_register", 64'(rsp_tdata[84:80]), 64'(want.index_reg));
               compare_field("index_scale", 64'(rsp_tdata[88:85]), 64'(want.scale));
               compare_field("target_displacement", 64'(rsp_tdata[120:89]),
                             64'(want.disp));
            end
            result_no++;
         end
         results_owed <= decoded_q.size();
      end
   end

endmodule

// ----- verif/x86_branch_decode_and_condition_top_tb.sv -----
module x86_branch_decode_and_condition_top_tb;

   import xbdc_pkg::*;
   import xbdc_tb_pkg::*;

   localparam int RANDOM_PER_PHASE = 320;
   localparam int NUM_PHASES       = 5;
   localparam int QUIET_LIMIT      = 2000;
   localparam int DRAIN_CYCLES     = 10;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;
   int mismatches;
   int owed;

   // idle percentages per phase: sender, receiver
   int phase_idle[NUM_PHASES]  = '{0, 58, 0, 27, 0};
   int phase_stall[NUM_PHASES] = '{0, 0, 58, 27, 0};

   x86_branch_decode_and_condition_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   xbdc_branch_checker branch_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatches),
      .results_owed   (owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // ends the run when neither channel has moved a transfer for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("x86_branch_decode_and_condition_top test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic insn_type random_insn();
      insn_type t;
      int       pick;
      t.insn_address       = {$urandom, $urandom};
      if ($urandom_range(9) == 0)
         t.insn_address[63:16] = '1;  // close to the top so the target wraps
      t.insn_length        = 4'($urandom);
      t.opcode_second      = 8'($urandom);
      t.modrm_byte         = 8'($urandom);
      t.sib_byte           = 8'($urandom);
      t.immediate_value    = $urandom;
      t.displacement_value = $urandom;
      t.flag_bits          = 12'($urandom);
      t.count_register     = ($urandom_range(3) == 0) ? 64'd0 : {$urandom, $urandom};
      case ($urandom_range(3))
         0:       t.rex_byte = '0;
         1, 2:    t.rex_byte = {REX_HI, 4'($urandom)};
         default: t.rex_byte = 8'($urandom);
      endcase
      if ($urandom_range(7) == 0)
         t.immediate_value = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;

      pick = $urandom_range(99);
      if (pick < 22) begin
         t.opcode_first = {JCC_SHORT_HI, 4'($urandom)};
      end else if (pick < 38) begin
         t.opcode_first  = OP_ESCAPE;
         t.opcode_second = {JCC_NEAR_HI, 4'($urandom)};
      end else if (pick < 42) begin
         t.opcode_first = OP_ESCAPE;
      end else if (pick < 46) begin
         t.opcode_first = OP_CALL_REL;
      end else if (pick < 49) begin
         t.opcode_first = OP_JMP_REL;
      end else if (pick < 52) begin
         t.opcode_first = OP_JMP_SHRT;
      end else if (pick < 60) begin
         t.opcode_first = OP_JRCXZ;
      end else if (pick < 92) begin
         t.opcode_first = OP_GRP5;
         if (pick < 84)
            t.modrm_byte[5:3] = 3'($urandom_range(GRP5_JMP, GRP5_CALL));
      end else begin
         t.opcode_first = 8'($urandom);
      end
      return t;
   endfunction

   function automatic insn_type shaped_insn(input logic [7:0] op1, input logic [7:0] op2,
                                            input logic [7:0] rex, input logic [7:0] modrm,
                                            input logic [7:0] sib);
      insn_type t;
      t               = random_insn();
      t.opcode_first  = op1;
      t.opcode_second = op2;
      t.rex_byte      = rex;
      t.modrm_byte    = modrm;
      t.sib_byte      = sib;
      return t;
   endfunction

   task automatic send_insn(input insn_type insn);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= insn;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      insn_type insn;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // direct forms at the edges of the target sum
      insn = shaped_insn(OP_CALL_REL, 8'h00, 8'h00, 8'h00, 8'h00);
      insn.insn_address    = '1;
      insn.insn_length     = 4'd15;
      insn.immediate_value = 32'h7fff_ffff;
      send_insn(insn);
      insn = shaped_insn(OP_CALL_REL, 8'h00, 8'h00, 8'h00, 8'h00);
      insn.insn_address    = '0;
      insn.insn_length     = 4'd0;
      insn.immediate_value = 32'h8000_0000;
      send_insn(insn);
      insn = shaped_insn(OP_JMP_REL, 8'h00, 8'h00, 8'h00, 8'h00);
      insn.immediate_value = '1;
      send_insn(insn);
      send_insn(shaped_insn(OP_JMP_SHRT, 8'h00, 8'h00, 8'h00, 8'h00));

      // jrcxz with rcx zero and with only the top bit set
      insn = shaped_insn(OP_JRCXZ, 8'h00, 8'h00, 8'h00, 8'h00);
      insn.count_register = '0;
      send_insn(insn);
      insn.count_register = 64'h8000_0000_0000_0000;
      send_insn(insn);

      // short and near jcc with all flags set and clear
      insn = shaped_insn({JCC_SHORT_HI, 4'h0}, 8'h00, 8'h00, 8'h00, 8'h00);
      insn.flag_bits = '1;
      send_insn(insn);
      insn = shaped_insn({JCC_SHORT_HI, 4'hf}, 8'h00, 8'h00, 8'h00, 8'h00);
      insn.flag_bits = '0;
      send_insn(insn);
      insn = shaped_insn(OP_ESCAPE, {JCC_NEAR_HI, 4'h0}, 8'h00, 8'h00, 8'h00);
      insn.flag_bits = '0;
      send_insn(insn);
      insn = shaped_insn(OP_ESCAPE, {JCC_NEAR_HI, 4'hf}, 8'h00, 8'h00, 8'h00);
      insn.flag_bits = '1;
      send_insn(insn);
      send_insn(shaped_insn(OP_ESCAPE, {JCC_SHORT_HI, 4'hf}, 8'h00, 8'h00, 8'h00));
      send_insn(shaped_insn(OP_ESCAPE, OP_NOP, 8'h00, 8'h00, 8'h00));

      // indirect forms: register, rip-relative, sib corner cases, bad rex
      send_insn(shaped_insn(OP_GRP5, 8'h00, {REX_HI, 4'h1}, {MOD_REG, GRP5_CALL, 3'd7}, 8'h00));
      send_insn(shaped_insn(OP_GRP5, 8'h00, {REX_HI, 4'hf},
                            {MOD_IND, GRP5_CALL_FAR, RM_DISP}, 8'h00));
      send_insn(shaped_insn(OP_GRP5, 8'h00, {REX_HI, 4'h1}, {MOD_IND, GRP5_JMP, RM_SIB},
                            {2'd3, IDX_NONE[2:0], RM_DISP}));
      send_insn(shaped_insn(OP_GRP5, 8'h00, {REX_HI, 4'h2}, {MOD_DISP8, GRP5_JMP, RM_SIB},
                            {2'd0, IDX_NONE[2:0], RM_DISP}));
      insn = shaped_insn(OP_GRP5, 8'h00, 8'h00, {MOD_DISP32, GRP5_CALL, RM_SIB},
                         {2'd2, IDX_NONE[2:0], RM_SIB});
      insn.displacement_value = 32'h8000_0000;
      send_insn(insn);
      send_insn(shaped_insn(OP_GRP5, 8'h00, 8'h5f, {MOD_DISP32, GRP5_CALL, RM_DISP}, 8'h00));

      // group 5 members and opcodes that are not branches
      send_insn(shaped_insn(OP_GRP5, 8'h00, 8'h00, {MOD_IND, GRP5_INC, 3'd0}, 8'h00));
      send_insn(shaped_insn(OP_GRP5, 8'h00, 8'h00, {MOD_REG, GRP5_PUSH, 3'd3}, 8'h00));
      send_insn(shaped_insn(OP_GRP5, 8'h00, 8'hff, {MOD_REG, GRP5_RSVD, 3'd7}, 8'hff));
      insn                    = '1;
      insn.opcode_first       = OP_NOP;
      send_insn(insn);
      send_insn('0);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         send_idle_pct  = phase_idle[phase];
         recv_stall_pct = phase_stall[phase];
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_insn(random_insn());
      end
      req_tvalid <= 1'b0;
      recv_stall_pct = 0;

      do @(posedge clock); while (owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("x86_branch_decode_and_condition_top test passed");
      end else begin
         $display("x86_branch_decode_and_condition_top test failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/xbdc_pkg.sv
rtl/core/x86_branch_decode_and_condition_top.sv
verif/xbdc_branch_checker.sv
verif/x86_branch_decode_and_condition_top_tb.sv
